// ===== design/image_difference_threshold_counter_macros.svh =====
// Assertion helpers for the image difference block.
`ifndef IMAGE_DIFFERENCE_THRESHOLD_COUNTER_MACROS_SVH
`define IMAGE_DIFFERENCE_THRESHOLD_COUNTER_MACROS_SVH

// same-cycle implication, checked on every rising clk edge out of reset
`define IDTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("idtc assertion failed");

// next-cycle implication
`define IDTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("idtc assertion failed");

`endif

// ===== design/idtc_pkg.sv =====
package idtc_pkg;

	localparam int CHAN_W  = 8;
	localparam int SUM_W   = 10;
	localparam int THR_W   = 10;
	localparam int PCT_W   = 14;
	localparam int TOTAL_W = 25;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [CHAN_W-1:0] CHAN_MAX         = 8'd255;
	localparam logic [CHAN_W-1:0] BRIGHTEN         = 8'd100;
	localparam logic [PCT_W-1:0]  SCALE_HUNDREDTHS = 14'd10000;

	// register index, taken from paddr[2]
	localparam logic REG_THRESHOLD = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_HOLD
	} idtc_state_t;

	typedef struct packed {
		logic take_pix;
		logic mul_en;
		logic div_en;
		logic hold;
	} idtc_ctrl_t;

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] r;
		if (a >= b) begin
			r = a - b;
		end else begin
			r = b - a;
		end
		return r;
	endfunction

	function automatic logic [CHAN_W-1:0] brighten(input logic [CHAN_W-1:0] d);
		logic [CHAN_W:0] s;
		logic [CHAN_W-1:0] r;
		s = {1'b0, d} + {1'b0, BRIGHTEN};
		if (s > {1'b0, CHAN_MAX}) begin
			r = CHAN_MAX;
		end else begin
			r = s[CHAN_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/idtc_if.sv =====
interface idtc_pix_if;
	import idtc_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] test_red;
	logic [CHAN_W-1:0] test_green;
	logic [CHAN_W-1:0] test_blue;
	logic [CHAN_W-1:0] ref_red;
	logic [CHAN_W-1:0] ref_green;
	logic [CHAN_W-1:0] ref_blue;
	logic              last_pixel;

	modport source (output valid, test_red, test_green, test_blue,
		ref_red, ref_green, ref_blue, last_pixel, input ready);
	modport sink (input valid, test_red, test_green, test_blue,
		ref_red, ref_green, ref_blue, last_pixel, output ready);
endinterface

interface idtc_res_if;
	import idtc_pkg::*;
	logic               valid;
	logic               ready;
	logic [CHAN_W-1:0]  diff_red;
	logic [CHAN_W-1:0]  diff_green;
	logic [CHAN_W-1:0]  diff_blue;
	logic               pixel_differs;
	logic               frame_done;
	logic [TOTAL_W-1:0] differing_total;
	logic [PCT_W-1:0]   percent_hundredths;
	logic               frame_failed;

	modport source (output valid, diff_red, diff_green, diff_blue, pixel_differs,
		frame_done, differing_total, percent_hundredths, frame_failed, input ready);
	modport sink (input valid, diff_red, diff_green, diff_blue, pixel_differs,
		frame_done, differing_total, percent_hundredths, frame_failed, output ready);
endinterface

// ===== design/image_difference_threshold_counter.sv =====
// Ordinary pixel: accepted in IDLE and held in HOLD until the output register is free to take it.
// Last pixel: a multiply (count * 10000), then a restoring divider that retires one
// quotient bit per cycle on one shared subtractor; then HOLD as for an ordinary pixel.
// The output register lets the next pixel enter while a result beat waits on res.
// arst_n clears the state machine, both counters, the threshold and res.valid; no clear pass.
module image_difference_threshold_counter import idtc_pkg::*; #(
	parameter int unsigned MAX_FRAME_PIXELS = 16777216
) (
	input  logic              clk,
	input  logic              arst_n,
	idtc_pix_if.sink          pix,
	idtc_res_if.source        res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// counters hold 0..MAX_FRAME_PIXELS
	localparam int CNT_W  = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int NUM_W  = CNT_W + PCT_W;
	localparam int STEP_W = $clog2(PCT_W);
	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_FRAME_PIXELS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PCT_W - 1);

	idtc_state_t state_q, state_d;
	idtc_ctrl_t  ctrl;

	logic [THR_W-1:0] threshold_q;
	logic [CNT_W-1:0] pcnt_q, dcnt_q;

	// ---------------------------------------------------------------
	// APB register port: one register, index taken from paddr[2]
	// ---------------------------------------------------------------
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_wr && paddr[2] == REG_THRESHOLD) begin
			threshold_q <= pwdata[THR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_THRESHOLD) begin
			prdata = DATA_W'(threshold_q);
		end
	end

	// ---------------------------------------------------------------
	// Per-pixel datapath, evaluated in the accept cycle
	// ---------------------------------------------------------------
	logic [CHAN_W-1:0] dr, dg, db;
	logic [SUM_W-1:0]  dsum;
	logic              differs;
	logic [CNT_W-1:0]  pcnt_n, dcnt_inc, dcnt_n;
	logic              accept;

	assign accept = pix.valid && ctrl.take_pix;
	assign pix.ready = ctrl.take_pix;

	always_comb begin
		dr      = abs_diff(pix.test_red,   pix.ref_red);
		dg      = abs_diff(pix.test_green, pix.ref_green);
		db      = abs_diff(pix.test_blue,  pix.ref_blue);
		dsum    = SUM_W'(dr) + SUM_W'(dg) + SUM_W'(db);
		differs = dsum > threshold_q;
		// saturating counts; differing never passes the pixel count
		pcnt_n   = (pcnt_q >= CNT_MAX) ? CNT_MAX : pcnt_q + 1'b1;
		dcnt_inc = dcnt_q;
		if (differs) begin
			dcnt_inc = (dcnt_q >= CNT_MAX) ? CNT_MAX : dcnt_q + 1'b1;
		end
		dcnt_n = (dcnt_inc > pcnt_n) ? pcnt_n : dcnt_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= '0;
			dcnt_q <= '0;
		end else if (accept) begin
			if (pix.last_pixel) begin
				pcnt_q <= '0;
				dcnt_q <= '0;
			end else begin
				pcnt_q <= pcnt_n;
				dcnt_q <= dcnt_n;
			end
		end
	end

	// pending result, waiting for the divider and then for the output register
	logic [CHAN_W-1:0]  hr_q, hg_q, hb_q;
	logic               hdiff_q, hlast_q;
	logic [TOTAL_W-1:0] htotal_q;

	// divider: rem_q starts as the numerator, den_q walks down from pixels << 13
	logic [NUM_W-1:0]  rem_q, den_q;
	logic [PCT_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W:0]    trial;
	logic              fits;

	assign trial = {1'b0, rem_q} - {1'b0, den_q};
	assign fits  = !trial[NUM_W];

	always_ff @(posedge clk) begin
		if (accept) begin
			hr_q    <= differs ? brighten(dr) : dr;
			hg_q    <= differs ? brighten(dg) : dg;
			hb_q    <= differs ? brighten(db) : db;
			hdiff_q <= differs;
			hlast_q <= pix.last_pixel;
			htotal_q <= pix.last_pixel ? TOTAL_W'(dcnt_n) : '0;
			rem_q   <= NUM_W'(dcnt_n);
			den_q   <= NUM_W'(pcnt_n) << (PCT_W - 1);
			quo_q   <= '0;
			step_q  <= LAST_STEP;
		end else if (ctrl.mul_en) begin
			// count * 10000, at most CNT_W x 14 bits
			rem_q <= NUM_W'(rem_q[CNT_W-1:0]) * NUM_W'(SCALE_HUNDREDTHS);
		end else if (ctrl.div_en) begin
			if (fits) begin
				rem_q <= trial[NUM_W-1:0];
			end
			quo_q  <= {quo_q[PCT_W-2:0], fits};
			den_q  <= den_q >> 1;
			step_q <= step_q - 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	logic out_free;
	logic res_valid_q;
	assign out_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pix.valid) begin
					state_d = pix.last_pixel ? ST_MUL : ST_HOLD;
				end
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (step_q == '0) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: ctrl.take_pix = 1'b1;
			ST_MUL:  ctrl.mul_en   = 1'b1;
			ST_DIV:  ctrl.div_en   = 1'b1;
			ST_HOLD: ctrl.hold     = 1'b1;
			default: ctrl = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	logic load_out;
	assign load_out = ctrl.hold && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	logic [CHAN_W-1:0]  or_q, og_q, ob_q;
	logic               odiff_q, olast_q, ofail_q;
	logic [TOTAL_W-1:0] ototal_q;
	logic [PCT_W-1:0]   opct_q;

	always_ff @(posedge clk) begin
		if (load_out) begin
			or_q     <= hr_q;
			og_q     <= hg_q;
			ob_q     <= hb_q;
			odiff_q  <= hdiff_q;
			olast_q  <= hlast_q;
			ototal_q <= htotal_q;
			opct_q   <= quo_q;
			ofail_q  <= hlast_q && (quo_q != '0);
		end
	end

	assign res.valid              = res_valid_q;
	assign res.diff_red           = or_q;
	assign res.diff_green         = og_q;
	assign res.diff_blue          = ob_q;
	assign res.pixel_differs      = odiff_q;
	assign res.frame_done         = olast_q;
	assign res.differing_total    = ototal_q;
	assign res.percent_hundredths = opct_q;
	assign res.frame_failed       = ofail_q;

endmodule

// ===== design/idtc_checker.sv =====
`include "image_difference_threshold_counter_macros.svh"

module idtc_checker import idtc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [CHAN_W-1:0]  diff_red,
	input logic [CHAN_W-1:0]  diff_green,
	input logic [CHAN_W-1:0]  diff_blue,
	input logic               pixel_differs,
	input logic               frame_done,
	input logic [TOTAL_W-1:0] differing_total,
	input logic [PCT_W-1:0]   percent_hundredths,
	input logic               frame_failed
);

	`IDTC_ASSERT_NEXT(a_valid_holds, clk, arst_n, out_valid && !out_ready, out_valid)
	`IDTC_ASSERT_NOW(a_mid_frame_zero, clk, arst_n, out_valid && !frame_done, differing_total == '0 && percent_hundredths == '0 && !frame_failed)
	`IDTC_ASSERT_NOW(a_pct_range, clk, arst_n, out_valid, percent_hundredths <= SCALE_HUNDREDTHS)
	`IDTC_ASSERT_NOW(a_fail_flag, clk, arst_n, out_valid, frame_failed == (frame_done && percent_hundredths != '0))
	`IDTC_ASSERT_NOW(a_brightened, clk, arst_n, out_valid && pixel_differs, diff_red >= BRIGHTEN && diff_green >= BRIGHTEN && diff_blue >= BRIGHTEN)

endmodule

bind image_difference_threshold_counter idtc_checker u_idtc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (res.valid),
	.out_ready          (res.ready),
	.diff_red           (res.diff_red),
	.diff_green         (res.diff_green),
	.diff_blue          (res.diff_blue),
	.pixel_differs      (res.pixel_differs),
	.frame_done         (res.frame_done),
	.differing_total    (res.differing_total),
	.percent_hundredths (res.percent_hundredths),
	.frame_failed       (res.frame_failed)
);

// ===== test/idtc_result_checker.sv =====
module idtc_result_checker import idtc_pkg::*; #(
	parameter int unsigned MAX_FRAME_PIXELS = 16777216
) (
	input  logic              clk,
	input  logic              arst_n,
	idtc_pix_if               pix,
	idtc_res_if               res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic [DATA_W-1:0] prdata,
	input  logic              pready,
	output int                fail_count,
	output int                pending,
	output int                frames_closed,
	output int                flagged_pixels
);

	typedef struct {
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic               differs;
		logic               done;
		logic [TOTAL_W-1:0] total;
		logic [PCT_W-1:0]   share;
		logic               failed;
	} pixel_outcome_t;

	pixel_outcome_t   due_results[$];
	logic [THR_W-1:0] threshold;
	longint unsigned  frame_pixels;
	longint unsigned  frame_flagged;
	int               beats;

	function automatic logic [CHAN_W-1:0] chan_gap(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// +100, clipped at full scale
	function automatic logic [CHAN_W-1:0] lift(input logic [CHAN_W-1:0] d);
		int s;
		s = int'(d) + int'(BRIGHTEN);
		return (s > int'(CHAN_MAX)) ? CHAN_MAX : CHAN_W'(s);
	endfunction

	function automatic longint unsigned bump(input longint unsigned c);
		return (c >= MAX_FRAME_PIXELS) ? longint'(MAX_FRAME_PIXELS) : c + 1;
	endfunction

	// outcome of the pixel on the input bus; advances the frame counters
	function automatic pixel_outcome_t predict_pixel();
		pixel_outcome_t  o;
		int              gap_sum;
		longint unsigned ratio;
		o.red   = chan_gap(pix.test_red, pix.ref_red);
		o.green = chan_gap(pix.test_green, pix.ref_green);
		o.blue  = chan_gap(pix.test_blue, pix.ref_blue);
		gap_sum = int'(o.red) + int'(o.green) + int'(o.blue);
		o.differs = gap_sum > int'(threshold);
		o.done    = pix.last_pixel;
		o.total   = '0;
		o.share   = '0;
		o.failed  = 1'b0;
		frame_pixels = bump(frame_pixels);
		if (o.differs) begin
			frame_flagged = bump(frame_flagged);
			o.red   = lift(o.red);
			o.green = lift(o.green);
			o.blue  = lift(o.blue);
		end
		if (frame_flagged > frame_pixels) begin
			frame_flagged = frame_pixels;
		end
		if (o.done) begin
			ratio    = frame_flagged * SCALE_HUNDREDTHS / frame_pixels;
			o.total  = TOTAL_W'(frame_flagged);
			o.share  = PCT_W'(ratio);
			o.failed = ratio != 0;
			frame_flagged = 0;
			frame_pixels  = 0;
		end
		return o;
	endfunction

	function automatic void compare_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("%s: expected %0h, got %0h (result beat %0d)", name, want, got, beats);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_outcome_t want;
		if (!arst_n) begin
			due_results.delete();
			threshold      = '0;
			frame_pixels   = 0;
			frame_flagged  = 0;
			beats          = 0;
			fail_count     = 0;
			frames_closed  = 0;
			flagged_pixels = 0;
		end else begin
			if (res.valid && res.ready) begin
				beats++;
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("result beat %0d arrived with nothing outstanding", beats);
					end
				end else begin
					want = due_results.pop_front();
					compare_field("diff_red", 64'(want.red), 64'(res.diff_red));
					compare_field("diff_green", 64'(want.green), 64'(res.diff_green));
					compare_field("diff_blue", 64'(want.blue), 64'(res.diff_blue));
					compare_field("pixel_differs", 64'(want.differs),
						64'(res.pixel_differs));
					compare_field("frame_done", 64'(want.done), 64'(res.frame_done));
					compare_field("differing_total", 64'(want.total),
						64'(res.differing_total));
					compare_field("percent_hundredths", 64'(want.share),
						64'(res.percent_hundredths));
					compare_field("frame_failed", 64'(want.failed), 64'(res.frame_failed));
					if (want.done) begin
						frames_closed++;
					end
					if (want.differs) begin
						flagged_pixels++;
					end
				end
			end
			if (pix.valid && pix.ready) begin
				due_results.push_back(predict_pixel());
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_THRESHOLD) begin
						threshold = pwdata[THR_W-1:0];
					end
				end else begin
					compare_field("prdata", 64'(threshold), 64'(prdata));
				end
			end
		end
		pending = due_results.size();
	end

endmodule

// ===== test/tb.sv =====
module tb;
	import idtc_pkg::*;

	localparam int unsigned FRAME_PIXEL_BOUND = 16777216;
	localparam int          IDLE_PERCENT      = 11;
	localparam int          LONG_HOLD_CYCLES  = 90;
	localparam int          SETTLE_CYCLES     = 40;
	localparam int          PHASES            = 11;
	localparam int          PHASE_PIXELS      = 140;
	// one flagged pixel in seven: 1428.57 hundredths truncates to 1428
	localparam int          BIG_FRAME         = 7;

	localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};
	localparam logic [THR_W-1:0]  THR_TOP        = '1;     // above any reachable sum
	localparam logic [THR_W-1:0]  THR_FULL       = 10'd765; // largest reachable sum

	typedef struct {
		logic [CHAN_W-1:0] test_red;
		logic [CHAN_W-1:0] test_green;
		logic [CHAN_W-1:0] test_blue;
		logic [CHAN_W-1:0] ref_red;
		logic [CHAN_W-1:0] ref_green;
		logic [CHAN_W-1:0] ref_blue;
		logic              last;
	} pixel_pair_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic              pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;

	idtc_pix_if pix_bus();
	idtc_res_if res_bus();

	int fail_count;
	int pending;
	int frames_closed;
	int flagged_pixels;

	int pixels_sent   = 0;
	int settings_used = 0;
	int frame_left    = 0;  // pixels still to go in the open frame

	// calm: neither side idles. hold_request / hold_served hand the long
	// output stall to the sink process and back.
	logic calm         = 1'b0;
	logic hold_request = 1'b0;
	logic hold_served  = 1'b0;

	image_difference_threshold_counter #(
		.MAX_FRAME_PIXELS(FRAME_PIXEL_BOUND)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix_bus),
		.res     (res_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	idtc_result_checker #(
		.MAX_FRAME_PIXELS(FRAME_PIXEL_BOUND)
	) result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.pix            (pix_bus),
		.res            (res_bus),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.fail_count     (fail_count),
		.pending        (pending),
		.frames_closed  (frames_closed),
		.flagged_pixels (flagged_pixels)
	);

	initial begin : clock_gen
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result sink: random back-pressure, none while calm, plus one long
	// stall on request so the block backs up into its input.
	initial begin : result_sink
		res_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request && !hold_served) begin
				res_bus.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				hold_served = 1'b1;
			end else if (calm) begin
				res_bus.ready <= 1'b1;
			end else begin
				res_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	function automatic pixel_pair_t make_pair(input int tr, input int tg, input int tbl,
		input int rr, input int rg, input int rb, input logic last);
		pixel_pair_t p;
		p.test_red   = CHAN_W'(tr);
		p.test_green = CHAN_W'(tg);
		p.test_blue  = CHAN_W'(tbl);
		p.ref_red    = CHAN_W'(rr);
		p.ref_green  = CHAN_W'(rg);
		p.ref_blue   = CHAN_W'(rb);
		p.last       = last;
		return p;
	endfunction

	// channel moved by up to +/-span, clipped to the channel range
	function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] c, input int span);
		int v;
		v = int'(c) + int'($urandom_range(2 * span)) - span;
		if (v < 0) begin
			v = 0;
		end
		if (v > int'(CHAN_MAX)) begin
			v = int'(CHAN_MAX);
		end
		return CHAN_W'(v);
	endfunction

	// Mix of fully random pairs, near-identical pairs (sums close to low
	// thresholds), rail values, exact matches and pairs moved by up to +/-100.
	function automatic pixel_pair_t random_pair(input logic last);
		pixel_pair_t p;
		p.ref_red   = CHAN_W'($urandom);
		p.ref_green = CHAN_W'($urandom);
		p.ref_blue  = CHAN_W'($urandom);
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				p.test_red   = CHAN_W'($urandom);
				p.test_green = CHAN_W'($urandom);
				p.test_blue  = CHAN_W'($urandom);
			end
			4, 5, 6: begin
				p.test_red   = nudge(p.ref_red, 20);
				p.test_green = nudge(p.ref_green, 20);
				p.test_blue  = nudge(p.ref_blue, 20);
			end
			7: begin
				p.test_red   = $urandom_range(1) ? CHAN_MAX : '0;
				p.test_green = $urandom_range(1) ? CHAN_MAX : '0;
				p.test_blue  = $urandom_range(1) ? CHAN_MAX : '0;
				p.ref_red    = $urandom_range(1) ? CHAN_MAX : '0;
				p.ref_green  = $urandom_range(1) ? CHAN_MAX : '0;
				p.ref_blue   = $urandom_range(1) ? CHAN_MAX : '0;
			end
			8: begin
				p.test_red   = p.ref_red;
				p.test_green = p.ref_green;
				p.test_blue  = p.ref_blue;
			end
			default: begin
				p.test_red   = nudge(p.ref_red, 100);
				p.test_green = nudge(p.ref_green, 100);
				p.test_blue  = nudge(p.ref_blue, 100);
			end
		endcase
		p.last = last;
		return p;
	endfunction

	// Called and returns at a falling edge. Random gaps before the beat
	// unless calm.
	task automatic offer_pixel(input pixel_pair_t p);
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				pix_bus.valid <= 1'b0;
				@(negedge clk);
			end
		end
		pix_bus.valid      <= 1'b1;
		pix_bus.test_red   <= p.test_red;
		pix_bus.test_green <= p.test_green;
		pix_bus.test_blue  <= p.test_blue;
		pix_bus.ref_red    <= p.ref_red;
		pix_bus.ref_green  <= p.ref_green;
		pix_bus.ref_blue   <= p.ref_blue;
		pix_bus.last_pixel <= p.last;
		@(posedge clk);
		while (!pix_bus.ready) @(posedge clk);
		@(negedge clk);
		pixels_sent++;
	endtask

	// Frames of random length; mostly short, a few long, and now and then
	// one cut short. Frames run on across threshold changes.
	task automatic offer_stream(input int count);
		logic last;
		for (int n = 0; n < count; n++) begin
			if (frame_left == 0) begin
				frame_left = ($urandom_range(19) == 0) ? $urandom_range(150, 60)
					: $urandom_range(24, 1);
			end
			frame_left--;
			if ($urandom_range(39) == 0) begin
				frame_left = 0;
			end
			last = (frame_left == 0);
			offer_pixel(random_pair(last));
		end
	endtask

	// Stop offering and wait until every result beat has been taken.
	task automatic drain();
		pix_bus.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Write the threshold, then read it back in a back-to-back transfer.
	// Only called with the block drained.
	task automatic set_threshold(input logic [THR_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= THRESHOLD_ADDR;
		pwdata  <= DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		settings_used++;
	endtask

	initial begin : stimulus
		pixel_pair_t      p;
		logic [THR_W-1:0] thr;
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		pix_bus.valid      <= 1'b0;
		pix_bus.test_red   <= '0;
		pix_bus.test_green <= '0;
		pix_bus.test_blue  <= '0;
		pix_bus.ref_red    <= '0;
		pix_bus.ref_green  <= '0;
		pix_bus.ref_blue   <= '0;
		pix_bus.last_pixel <= 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed ---
		// threshold 0: any nonzero difference flags the pixel
		set_threshold('0);
		offer_pixel(make_pair(0, 0, 0, 0, 0, 0, 1'b0));       // sum 0, not above 0
		offer_pixel(make_pair(255, 255, 255, 0, 0, 0, 1'b0)); // full diff, lift clips
		offer_pixel(make_pair(0, 0, 0, 255, 255, 255, 1'b0)); // ref above test
		offer_pixel(make_pair(1, 0, 0, 0, 0, 0, 1'b0));       // smallest flagged sum
		offer_pixel(make_pair(155, 156, 0, 0, 0, 0, 1'b1));   // lift lands on / past 255
		offer_pixel(make_pair(77, 77, 77, 77, 77, 77, 1'b1)); // one-pixel frame, clean
		offer_pixel(make_pair(9, 200, 31, 10, 200, 31, 1'b1)); // one-pixel frame, all flagged
		drain();
		// strict compare at the top of the reachable range
		set_threshold(THR_FULL);
		offer_pixel(make_pair(255, 255, 255, 0, 0, 0, 1'b0));
		offer_pixel(make_pair(0, 0, 1, 255, 255, 255, 1'b0));
		offer_pixel(make_pair(128, 64, 32, 128, 64, 32, 1'b1));
		drain();
		set_threshold(THR_FULL - 10'd1);
		offer_pixel(make_pair(255, 255, 255, 0, 0, 0, 1'b1));
		offer_pixel(make_pair(255, 255, 254, 0, 0, 0, 1'b0));
		offer_pixel(make_pair(0, 0, 0, 255, 255, 255, 1'b1));
		drain();
		// threshold past 765: nothing can differ
		set_threshold(THR_TOP);
		offer_pixel(make_pair(255, 255, 255, 0, 0, 0, 1'b0));
		offer_pixel(random_pair(1'b1));
		drain();

		// short frame with a single flagged pixel: share is truncated
		set_threshold(THR_FULL - 10'd1);
		calm = 1'b1;
		offer_pixel(make_pair(255, 255, 255, 0, 0, 0, 1'b0));
		for (int n = 1; n < BIG_FRAME; n++) begin
			p = random_pair(n == BIG_FRAME - 1);
			p.test_red   = p.ref_red;
			p.test_green = p.ref_green;
			p.test_blue  = p.ref_blue;
			offer_pixel(p);
		end
		calm = 1'b0;
		drain();

		// --- random phases, one threshold each ---
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       thr = '0;
				1:       thr = THR_TOP;
				2:       thr = THR_FULL;
				3:       thr = 10'd1;
				4:       thr = 10'd150;
				5, 6:    thr = THR_W'($urandom_range(120));
				7:       thr = 10'd300;
				default: thr = THR_W'($urandom_range(int'(THR_TOP)));
			endcase
			set_threshold(thr);
			calm = (ph == 4);
			if (ph == 2) begin
				hold_request = 1'b1;
			end
			if (ph == 6) begin
				// sender pause in mid-frame until the block has emptied
				offer_stream(PHASE_PIXELS / 2);
				drain();
				offer_stream(PHASE_PIXELS - PHASE_PIXELS / 2);
			end else begin
				offer_stream(PHASE_PIXELS);
			end
			if (ph == 2) begin
				pix_bus.valid <= 1'b0;
				while (!hold_served) @(negedge clk);
			end
			drain();
		end
		calm = 1'b0;

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("%0d pixels over %0d threshold settings; %0d frames closed, %0d flagged",
			pixels_sent, settings_used, frames_closed, flagged_pixels);
		$display("covered clipping, strict compare at 764/765, unreachable threshold, %0s",
			"a truncated share on a seven-pixel frame and a long output stall");
		if (fail_count == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// timeout, far above the slowest correct run
	initial begin : watchdog
		#4000000;
		$display("timeout with %0d results outstanding", pending);
		$display("Mismatches found");
		$finish;
	end

endmodule
